[hw/rtl/chol_pkg.sv]
// ---------------------------------------------------------------------------
// chol_pkg: shared types and constants for the Cholesky factorization block
// Field widths, sequencer states and the request/response bundle of the
// shared iterative square-root / divide unit.
// ---------------------------------------------------------------------------
package chol_pkg;

  localparam int unsigned RowW      = 3;
  localparam int unsigned ValW      = 32;
  localparam int unsigned CfgW      = 4;
  localparam int unsigned DataW     = 40;
  localparam int unsigned SumW      = 64;
  localparam int unsigned MaxDimDef = 8;
  localparam logic [CfgW-1:0] CfgReset = 4'd8;

  typedef enum logic [1:0] {
    OP_SQRT,
    OP_DIV
  } op_e;

  typedef enum logic [3:0] {
    S_LOAD,
    S_ARD,
    S_AINIT,
    S_FRD,
    S_MUL,
    S_ACC,
    S_OP,
    S_BUSY,
    S_FAIL,
    S_ERD,
    S_ELD
  } state_e;

  typedef struct packed {
    logic              start;
    op_e               op;
    logic              neg;
    logic [SumW-1:0]   operand;
    logic [ValW-1:0]   divisor;
  } itu_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ValW-1:0]   result;
  } itu_rsp_t;

endpackage

[hw/rtl/chol_itu.sv]
// ---------------------------------------------------------------------------
// chol_itu: iterative square root and divide
// One restoring step per cycle: 32 steps for a 64-bit square root, 63 steps
// for a 63-bit by 32-bit divide. Results are saturated to signed 32 bits.
// ---------------------------------------------------------------------------
module chol_itu
  import chol_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  itu_req_t req_i,
  output itu_rsp_t rsp_o
);

  localparam logic [5:0] SqrtSteps = 6'd32;
  localparam logic [5:0] DivSteps  = 6'd63;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [5:0]      cnt_q, cnt_d;
  op_e             op_q, op_d;
  logic            neg_q, neg_d;
  logic [63:0]     sh_q, sh_d;
  logic [34:0]     rem_q, rem_d;
  logic [63:0]     acc_q, acc_d;
  logic [31:0]     dv_q, dv_d;
  logic [31:0]     res_q, res_d;

  logic [34:0]     rem_sh, trial;
  logic [63:0]     acc_nx, q_signed;

  // one step of the selected recurrence and the final saturation
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    neg_d  = neg_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    dv_d   = dv_q;
    res_d  = res_q;
    rem_sh = '0;
    trial  = '0;
    acc_nx = '0;
    q_signed = '0;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      neg_d  = req_i.neg;
      sh_d   = req_i.operand;
      dv_d   = req_i.divisor;
      rem_d  = '0;
      acc_d  = '0;
      cnt_d  = (req_i.op == OP_SQRT) ? SqrtSteps : DivSteps;
    end else if (busy_q) begin
      if (op_q == OP_SQRT) begin
        rem_sh = {rem_q[32:0], sh_q[63:62]};
        trial  = {1'b0, acc_q[31:0], 2'b01};
        sh_d   = {sh_q[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          acc_nx = {acc_q[62:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          acc_nx = {acc_q[62:0], 1'b0};
        end
      end else begin
        rem_sh = {rem_q[33:0], sh_q[63]};
        trial  = {3'b000, dv_q};
        sh_d   = {sh_q[62:0], 1'b0};
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          acc_nx = {acc_q[62:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          acc_nx = {acc_q[62:0], 1'b0};
        end
      end
      acc_d = acc_nx;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (op_q == OP_SQRT) begin
          res_d = acc_nx[31] ? 32'h7FFF_FFFF : acc_nx[31:0];
        end else begin
          q_signed = neg_q ? (64'd0 - acc_nx) : acc_nx;
          if (!q_signed[63] && q_signed[62:31] != '0) begin
            res_d = 32'h7FFF_FFFF;
          end else if (q_signed[63] && q_signed[62:31] != '1) begin
            res_d = 32'h8000_0000;
          end else begin
            res_d = q_signed[31:0];
          end
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    neg_q <= neg_d;
    sh_q  <= sh_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
    dv_q  <= dv_d;
    res_q <= res_d;
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

  // a start is never issued while an operation runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start)
    else $error("itu started while busy");

  // done follows the last step of a running operation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("itu done without a finished operation");

  // a divide result of a non-negative operand is never negative
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && op_q == OP_DIV && !neg_q |-> !res_q[31])
    else $error("itu divide sign error");

endmodule

[hw/rtl/cholesky_factorization_top.sv]
// ---------------------------------------------------------------------------
// cholesky_factorization_top: Cholesky factorization, signed Q15.16
// Loads a lower triangle, factors it with one shared multiplier and one
// iterative square-root / divide unit, then streams L in row-major order.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: one matrix element per transfer, tdata = {value, col, row},
//   tlast marks the final element and starts the factorization. Elements
//   above the diagonal or with row >= MAX_DIM are dropped.
//   Master stream: tdata = {factor_value, out_col, out_row}, tuser = status
//   (1 = not positive definite, one single result), tlast = final entry.
//   matrix_size is written through cfg_we_i / cfg_wdata_i while idle;
//   0 acts as 1, values above MAX_DIM as MAX_DIM.
// Sequencing:
//   Loading accepts one element per cycle (tready high while loading).
//   Each L entry reads its input, then for every earlier column reads two
//   factors, multiplies them on the shared 32x32 multiplier and accumulates,
//   then runs the square root (diagonal) or the divide (below diagonal).
//   Emission reads each entry and then loads it into the output register.
//   A receiver stall holds the output register and pauses the emit sweep.
// Reset: no loading state survives; matrix_size returns to 8, stores are
//   undefined until written.
// ---------------------------------------------------------------------------
module cholesky_factorization_top
  import chol_pkg::*;
#(
  parameter int unsigned MAX_DIM = MaxDimDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [DataW-1:0] s_axis_tdata,  // [2:0] row, [5:3] col, [37:6] value
  input  logic             s_axis_tlast,  // last
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [DataW-1:0] m_axis_tdata,  // [2:0] out_row, [5:3] out_col,
                                          // [37:6] factor_value
  output logic             m_axis_tuser,  // status
  output logic             m_axis_tlast   // last_result
);

  localparam int unsigned TriDepth = MAX_DIM * (MAX_DIM + 1) / 2;
  localparam int unsigned AW       = $clog2(TriDepth);
  localparam int unsigned IW       = $clog2(MAX_DIM);

  function automatic logic [AW-1:0] tri_addr(input logic [IW-1:0] r,
                                             input logic [IW-1:0] c);
    logic [2*IW+1:0] rr;
    logic [2*IW+1:0] t;
    rr = {{(IW+2){1'b0}}, r};
    t  = (rr * (rr + 1'b1)) >> 1;
    return AW'(t + {{(IW+2){1'b0}}, c});
  endfunction

  state_e state_q, state_d;

  logic [CfgW-1:0] cfg_q;
  logic [CfgW-1:0] dim;
  logic [IW-1:0]   last_idx;

  logic [IW-1:0]   i_q, i_d, j_q, j_d, k_q, k_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [SumW-1:0] prod_q;
  logic signed [SumW-1:0] prod_full;
  logic [ValW-1:0] diag_q;

  logic [ValW-1:0] in_mem [TriDepth];
  logic [ValW-1:0] f_mem  [TriDepth];
  logic [ValW-1:0] in_rd_q, fa_rd_q, fb_rd_q;
  logic [AW-1:0]   in_addr, fa_addr, fb_addr;

  logic [RowW-1:0] s_row, s_col;
  logic [ValW-1:0] s_val;
  logic            in_xfer, in_wr;

  logic            out_free, out_load, out_fail;
  logic            m_valid_q;
  logic [RowW-1:0] o_row_q, o_col_q;
  logic [ValW-1:0] o_val_q;
  logic            o_stat_q, o_last_q;

  itu_req_t        req;
  itu_rsp_t        rsp;
  logic [SumW-1:0] sq_in, mag, clamp_mag;
  logic            sum_pos;

  // unpack the input transfer
  assign s_row   = s_axis_tdata[2:0];
  assign s_col   = s_axis_tdata[5:3];
  assign s_val   = s_axis_tdata[37:6];
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign in_wr   = in_xfer && (s_col <= s_row) && ({1'b0, s_row} < MAX_DIM);

  // clamp the configured dimension
  always_comb begin
    if (cfg_q == '0) begin
      dim = CfgW'(1);
    end else if (cfg_q > CfgW'(MAX_DIM)) begin
      dim = CfgW'(MAX_DIM);
    end else begin
      dim = cfg_q;
    end
    last_idx = IW'(dim - CfgW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  assign sum_pos  = !sum_q[SumW-1] && (sum_q != '0);
  assign out_free = !m_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:  if (in_xfer && s_axis_tlast) state_d = S_ARD;
      S_ARD:   state_d = S_AINIT;
      S_AINIT: state_d = (i_q == '0) ? S_OP : S_FRD;
      S_FRD:   state_d = S_MUL;
      S_MUL:   state_d = S_ACC;
      S_ACC:   state_d = (k_q + 1'b1 == i_q) ? S_OP : S_FRD;
      S_OP: begin
        if (i_q == j_q && !sum_pos) begin
          state_d = S_FAIL;
        end else begin
          state_d = S_BUSY;
        end
      end
      S_BUSY: begin
        if (rsp.done) begin
          if (j_q == last_idx) begin
            state_d = (i_q == last_idx) ? S_ERD : S_ARD;
          end else begin
            state_d = S_ARD;
          end
        end
      end
      S_FAIL:  if (out_free) state_d = S_LOAD;
      S_ERD:   state_d = S_ELD;
      S_ELD: begin
        if (out_free) begin
          state_d = (j_q == i_q && i_q == last_idx) ? S_LOAD : S_ERD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // outputs of the sequencer: ready, addresses, output and failure load
  always_comb begin
    s_axis_tready = (state_q == S_LOAD);
    in_addr  = tri_addr(j_q, i_q);
    fa_addr  = tri_addr(i_q, k_q);
    fb_addr  = tri_addr(j_q, k_q);
    out_load = 1'b0;
    out_fail = 1'b0;
    case (state_q)
      S_ERD, S_ELD: fa_addr = tri_addr(i_q, j_q);
      default: ;
    endcase
    if (state_q == S_ELD && out_free) out_load = 1'b1;
    if (state_q == S_FAIL && out_free) out_fail = 1'b1;
  end

  // operand shaping for the shared unit
  always_comb begin
    sq_in = sum_q;
    if (sum_q[SumW-1:47] != '0) sq_in = {{(SumW-47){1'b0}}, {47{1'b1}}};
    mag = sum_q[SumW-1] ? (SumW'(0) - sum_q) : sum_q;
    clamp_mag = (mag > (SumW'(1) << 46)) ? (SumW'(1) << 46) : mag;
    req.start   = (state_q == S_OP) && !(i_q == j_q && !sum_pos);
    req.op      = (i_q == j_q) ? OP_SQRT : OP_DIV;
    req.neg     = sum_q[SumW-1];
    req.divisor = diag_q;
    if (i_q == j_q) begin
      req.operand = {1'b0, sq_in[46:0], 16'h0000};
    end else begin
      req.operand = {clamp_mag[46:0], 17'h00000};
    end
  end

  chol_itu u_itu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // index counters and accumulator
  always_comb begin
    i_d   = i_q;
    j_d   = j_q;
    k_d   = k_q;
    sum_d = sum_q;
    case (state_q)
      S_LOAD: begin
        i_d = '0;
        j_d = '0;
        k_d = '0;
      end
      S_AINIT: begin
        sum_d = {{(SumW-ValW){in_rd_q[ValW-1]}}, in_rd_q};
        k_d   = '0;
      end
      S_ACC: begin
        sum_d = sum_q - SumW'($signed(prod_q + SumW'(32768)) >>> 16);
        k_d   = k_q + 1'b1;
      end
      S_BUSY: begin
        if (rsp.done) begin
          if (j_q == last_idx) begin
            if (i_q == last_idx) begin
              i_d = '0;
              j_d = '0;
            end else begin
              i_d = i_q + 1'b1;
              j_d = i_q + 1'b1;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      S_ELD: begin
        if (out_free) begin
          if (j_q == i_q) begin
            i_d = i_q + 1'b1;
            j_d = '0;
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      m_valid_q <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      if (out_load || out_fail) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // full-width signed product of two factor entries
  assign prod_full = $signed(fa_rd_q) * $signed(fb_rd_q);

  // datapath: accumulator, product, diagonal
  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    prod_q <= prod_full;
    if (state_q == S_BUSY && rsp.done && i_q == j_q) diag_q <= rsp.result;
  end

  // element and factor stores
  always_ff @(posedge clk_i) begin
    if (in_wr) in_mem[tri_addr(IW'(s_row), IW'(s_col))] <= s_val;
    if (state_q == S_BUSY && rsp.done) f_mem[tri_addr(j_q, i_q)] <= rsp.result;
    in_rd_q <= in_mem[in_addr];
    fa_rd_q <= f_mem[fa_addr];
    fb_rd_q <= f_mem[fb_addr];
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_row_q  <= RowW'(i_q);
      o_col_q  <= RowW'(j_q);
      o_val_q  <= fa_rd_q;
      o_stat_q <= 1'b0;
      o_last_q <= (j_q == i_q) && (i_q == last_idx);
    end else if (out_fail) begin
      o_row_q  <= RowW'(i_q);
      o_col_q  <= RowW'(i_q);
      o_val_q  <= '0;
      o_stat_q <= 1'b1;
      o_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, o_val_q, o_col_q, o_row_q};
  assign m_axis_tuser  = o_stat_q;
  assign m_axis_tlast  = o_last_q;

  // a failure result always closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("failure result without tlast");

  // a non-positive diagonal sum leads to the failure state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OP && i_q == j_q && !sum_pos |=> state_q == S_FAIL)
    else $error("missed non-positive diagonal");

  // the unit only completes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> state_q == S_BUSY)
    else $error("unit done outside wait state");

  // no element is taken while the unit runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !rsp.busy)
    else $error("ready while unit busy");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Cholesky factorization block testbench
// Loads lower triangles of symmetric Q15.16 matrices over the slave stream,
// predicts the factor L (or the single failure result) in a local
// fixed-point model, and checks every master transfer field by field.
// A short directed table comes first, then random matrices of random size.
// ---------------------------------------------------------------------------
module testbench;
  import chol_pkg::*;

  localparam int unsigned Dim      = 8;
  localparam int unsigned TriDepth = Dim * (Dim + 1) / 2;
  localparam int unsigned QuietLimit = 20000;
  localparam int unsigned NumItems   = 370;
  localparam int unsigned TailItems  = 40;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [RowW-1:0] col;
    logic [ValW-1:0] value;
    logic            status;
    logic            last;
  } entry_t;

  typedef struct {
    bit              set_size;
    logic [CfgW-1:0] size;
    logic [RowW-1:0] row;
    logic [RowW-1:0] col;
    logic [ValW-1:0] value;
    logic            last;
    bit              typed;      // single expected entry given below
    logic [ValW-1:0] want_value;
    logic            want_status;
  } stim_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CfgW-1:0]  cfg_wdata_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata;
  logic             s_axis_tlast;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [DataW-1:0] m_axis_tdata;
  logic             m_axis_tuser;
  logic             m_axis_tlast;

  cholesky_factorization_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Local copy of the block's stores and size register
  logic signed [ValW-1:0] elem_store   [TriDepth];
  logic signed [ValW-1:0] factor_store [TriDepth];
  logic [CfgW-1:0]        size_reg;
  entry_t                 factor_q [$];
  entry_t                 run_out  [$];

  int unsigned errors, checked, runs, failures, items_sent;
  int unsigned quiet;
  bit          calm;

  // Free-running clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic int unsigned tri_idx(int unsigned r, int unsigned c);
    return r * (r + 1) / 2 + c;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Store one element; on the final one, factor and fill run_out
  task automatic factor_matrix(input logic [RowW-1:0] row, input logic [RowW-1:0] col,
                               input logic [ValW-1:0] value, input logic last);
    int unsigned dim;
    longint      sum, prod, d, lim, q;
    longint unsigned s, r;
    entry_t      e;
    run_out.delete();
    if (col <= row) elem_store[tri_idx(row, col)] = value;
    if (!last) return;
    dim = (size_reg == 0) ? 1 : ((size_reg > Dim) ? Dim : size_reg);
    lim = 64'sd1 <<< 46;
    for (int unsigned i = 0; i < dim; i++) begin
      for (int unsigned j = i; j < dim; j++) begin
        sum = longint'(elem_store[tri_idx(j, i)]);
        for (int unsigned k = 0; k < i; k++) begin
          prod = longint'(factor_store[tri_idx(i, k)]) * longint'(factor_store[tri_idx(j, k)]);
          sum  = sum - ((prod + 32768) >>> 16);
        end
        if (i == j) begin
          if (sum <= 0) begin
            e = '{row: i, col: i, value: '0, status: 1'b1, last: 1'b1};
            run_out.push_back(e);
            return;
          end
          s = sum;
          if (s > (64'd1 << 47) - 1) s = (64'd1 << 47) - 1;
          r = int_sqrt(s << 16);
          if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
          factor_store[tri_idx(i, i)] = r[31:0];
        end else begin
          d = longint'(factor_store[tri_idx(i, i)]);
          if (sum > lim) sum = lim;
          if (sum < -lim) sum = -lim;
          if (d <= 0) d = 1;
          q = (sum * 65536) / d;
          if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
          if (q < -64'sh8000_0000) q = -64'sh8000_0000;
          factor_store[tri_idx(j, i)] = q[31:0];
        end
      end
    end
    for (int unsigned i = 0; i < dim; i++)
      for (int unsigned j = 0; j <= i; j++) begin
        e = '{row: i, col: j, value: factor_store[tri_idx(i, j)], status: 1'b0,
              last: (i == dim - 1 && j == i)};
        run_out.push_back(e);
      end
  endtask

  // Drive one element and wait for its transfer
  task automatic send_elem(input logic [RowW-1:0] row, input logic [RowW-1:0] col,
                           input logic [ValW-1:0] value, input logic last);
    if (!calm && $urandom_range(0, 99) < 36) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 36);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, value, col, row};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    factor_matrix(row, col, value, last);
  endtask

  // Drop valid and let the block drain before touching the register
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (factor_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [CfgW-1:0] size);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    size_reg = size;
  endtask

  task automatic queue_run(input bit typed, input logic [ValW-1:0] v, input logic st);
    entry_t e;
    if (run_out.size() == 0) return;
    runs++;
    if (run_out[0].status) failures++;
    if (typed) begin
      e = '{row: 0, col: 0, value: v, status: st, last: 1'b1};
      factor_q.push_back(e);
    end else begin
      foreach (run_out[n]) factor_q.push_back(run_out[n]);
    end
  endtask

  // Random symmetric matrix, elements in random order, full triangle loaded
  task automatic random_matrix();
    int unsigned dim, pick, tmp;
    int unsigned pos [$];
    bit          noisy;
    logic [ValW-1:0] v;
    dim   = (size_reg == 0) ? 1 : ((size_reg > Dim) ? Dim : size_reg);
    noisy = ($urandom_range(0, 99) < 20);
    for (int unsigned n = 0; n < dim * (dim + 1) / 2; n++) pos.push_back(n);
    for (int n = pos.size() - 1; n > 0; n--) begin
      pick = $urandom_range(0, n);
      tmp = pos[n]; pos[n] = pos[pick]; pos[pick] = tmp;
    end
    foreach (pos[n]) begin
      int unsigned r, c;
      r = 0;
      while (tri_idx(r + 1, 0) <= pos[n]) r++;
      c = pos[n] - tri_idx(r, 0);
      if (noisy) v = $urandom;
      else if (r == c) v = (dim << 17) + $urandom_range(0, 32'h0040_0000);
      else v = $urandom_range(0, 32'h0001_FFFF) - 32'h0001_0000;
      // stray element above the diagonal, ignored by the block
      if ($urandom_range(0, 99) < 8) begin
        c = $urandom_range(0, 6);
        send_elem($urandom_range(0, c), $urandom_range(c + 1, 7) , $urandom, 1'b0);
        c = pos[n] - tri_idx(r, 0);
      end
      send_elem(r, c, v, n == pos.size() - 1);
    end
    queue_run(1'b0, '0, 1'b0);
  endtask

  stim_t table_q [$];

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    size_reg      = CfgReset;
    calm          = 1'b0;
    for (int n = 0; n < TriDepth; n++) begin
      elem_store[n] = '0;
      factor_store[n] = '0;
    end

    // set_size, size, row, col, value, last, typed, want_value, want_status
    table_q = '{
      '{1, 4'd1,  3'd0, 3'd0, 32'h0001_0000, 1, 1, 32'h0001_0000, 0},
      '{1, 4'd0,  3'd0, 3'd0, 32'h0000_0000, 1, 1, 32'h0000_0000, 1},
      '{0, 4'd0,  3'd0, 3'd0, 32'h8000_0000, 1, 1, 32'h0000_0000, 1},
      '{0, 4'd0,  3'd0, 3'd0, 32'hFFFF_FFFF, 1, 1, 32'h0000_0000, 1},
      '{0, 4'd0,  3'd0, 3'd0, 32'h7FFF_FFFF, 1, 0, '0, 0},
      '{0, 4'd0,  3'd1, 3'd3, 32'hFFFF_FFFF, 0, 0, '0, 0},
      '{0, 4'd0,  3'd0, 3'd0, 32'h0004_0000, 1, 1, 32'h0002_0000, 0},
      '{1, 4'd2,  3'd0, 3'd0, 32'h0004_0000, 0, 0, '0, 0},
      '{0, 4'd0,  3'd1, 3'd0, 32'h0002_0000, 0, 0, '0, 0},
      '{0, 4'd0,  3'd1, 3'd1, 32'h0005_0000, 1, 0, '0, 0},
      '{0, 4'd0,  3'd6, 3'd7, 32'h1234_5678, 1, 0, '0, 0},
      '{0, 4'd0,  3'd0, 3'd0, 32'h0000_0001, 0, 0, '0, 0},
      '{0, 4'd0,  3'd1, 3'd0, 32'h7FFF_FFFF, 0, 0, '0, 0},
      '{0, 4'd0,  3'd1, 3'd1, 32'h7FFF_FFFF, 1, 0, '0, 0},
      '{0, 4'd0,  3'd1, 3'd0, 32'h8000_0000, 0, 0, '0, 0},
      '{0, 4'd0,  3'd1, 3'd1, 32'h0000_0001, 1, 0, '0, 0},
      '{0, 4'd0,  3'd7, 3'd7, 32'h0001_0000, 0, 0, '0, 0},
      '{0, 4'd0,  3'd0, 3'd0, 32'h0001_0000, 1, 0, '0, 0}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (table_q[n]) begin
      if (table_q[n].set_size) write_size(table_q[n].size);
      send_elem(table_q[n].row, table_q[n].col, table_q[n].value, table_q[n].last);
      queue_run(table_q[n].typed, table_q[n].want_value, table_q[n].want_status);
    end

    // Largest size through an out-of-range write, then random sizes
    write_size(4'd15);
    random_matrix();
    while (items_sent < NumItems - TailItems) begin
      calm = (items_sent > 150 && items_sent < 230);
      write_size(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4));
      random_matrix();
    end
    write_size(4'd8);
    random_matrix();

    drain();
    repeat (100) @(posedge clk_i);
    $display("Ran %0d elements into %0d factorizations (%0d not positive definite),",
             items_sent, runs, failures);
    $display("checked %0d factor transfers.", checked);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Receiver: check each transfer, then choose tready for the next cycle
  always @(posedge clk_i) begin
    entry_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{row: m_axis_tdata[2:0], col: m_axis_tdata[5:3], value: m_axis_tdata[37:6],
              status: m_axis_tuser, last: m_axis_tlast};
      checked++;
      if (factor_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer %h", $realtime, got);
      end else begin
        want = factor_q.pop_front();
        if (got.row !== want.row || got.col !== want.col)
          $display("%0t: position expected (%0d,%0d) actual (%0d,%0d)", $realtime,
                   want.row, want.col, got.row, got.col);
        if (got.value !== want.value)
          $display("%0t: factor_value expected %h actual %h", $realtime, want.value, got.value);
        if (got.status !== want.status)
          $display("%0t: status expected %b actual %b", $realtime, want.status, got.status);
        if (got.last !== want.last)
          $display("%0t: last expected %b actual %b", $realtime, want.last, got.last);
        if (got !== want) errors++;
      end
    end
    m_axis_tready <= rst_ni && (calm || $urandom_range(0, 99) >= 36);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("%0t: no transfer for %0d cycles", $realtime, quiet);
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

[cholesky_factorization_top.f]
hw/rtl/chol_pkg.sv
hw/rtl/chol_itu.sv
hw/rtl/cholesky_factorization_top.sv
verif/testbench.sv
